FILE: rtl/core/cpj_pkg.sv
// ----------------------------------------------------------------------------
// cpj_pkg
// Shared types, widths, codes and saturation helper for the cascaded PD
// jerk controller.
// ----------------------------------------------------------------------------
package cpj_pkg;

  localparam int JOINTS  = 6;
  localparam int JOINT_W = 3;
  localparam logic [JOINT_W-1:0] JOINT_MAX = JOINT_W'(JOINTS - 1);

  localparam int DATA_W = 32;
  localparam int GAIN_W = 24;
  localparam int INV_W  = 27;

  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 27;

  localparam int MUL_A_W    = 33;
  localparam int DIG_W      = 4;
  localparam int MUL_DIGITS = 7;
  localparam int MUL_B_W    = DIG_W * MUL_DIGITS;
  localparam int MUL_CNT_W  = 3;
  localparam int MUL_HI_W   = MUL_A_W + 1;
  localparam int MUL_P_W    = MUL_HI_W + MUL_B_W;
  localparam int FRAC_W     = 16;
  localparam int PQ_W       = MUL_P_W - FRAC_W;
  localparam int SAT_W      = PQ_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_P = 3'd0,
    REG_POS_D = 3'd1,
    REG_VEL_P = 3'd2,
    REG_VEL_D = 3'd3,
    REG_ACC_P = 3'd4,
    REG_ACC_D = 3'd5,
    REG_INV_T = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STG_POS = 2'd0,
    STG_VEL = 2'd1,
    STG_ACC = 2'd2
  } stage_t;

  typedef enum logic [1:0] {
    OP_P     = 2'd0,
    OP_D     = 2'd1,
    OP_SCALE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_LOAD,
    S_RUN,
    S_SUM,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [GAIN_W-1:0] pos_p;
    logic [GAIN_W-1:0] pos_d;
    logic [GAIN_W-1:0] vel_p;
    logic [GAIN_W-1:0] vel_d;
    logic [GAIN_W-1:0] acc_p;
    logic [GAIN_W-1:0] acc_d;
    logic [INV_W-1:0]  inv_t;
  } gains_t;

  typedef struct packed {
    logic [JOINT_W-1:0]       joint;
    logic                     restart;
    logic signed [DATA_W-1:0] goal;
    logic signed [DATA_W-1:0] pos;
    logic signed [DATA_W-1:0] vel;
    logic signed [DATA_W-1:0] acc;
  } item_t;

  typedef struct packed {
    logic [JOINT_W-1:0]       joint;
    logic signed [DATA_W-1:0] jerk;
  } result_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic fits;
    fits = (v[SAT_W-1:DATA_W-1] == '0) || (v[SAT_W-1:DATA_W-1] == '1);
    if (fits) begin
      return v[DATA_W-1:0];
    end else if (v[SAT_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

FILE: rtl/core/cpj_serial_mult.sv
// ----------------------------------------------------------------------------
// cpj_serial_mult
// Digit-serial multiplier: signed multiplicand times unsigned multiplier,
// one 4-bit multiplier digit per cycle, least significant digit first.
// ----------------------------------------------------------------------------
module cpj_serial_mult (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [cpj_pkg::MUL_A_W-1:0]   a,
  input  logic        [cpj_pkg::MUL_B_W-1:0]   b,
  output logic                                 done,
  output logic signed [cpj_pkg::MUL_P_W-1:0]   prod
);
  import cpj_pkg::*;

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [MUL_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic signed [MUL_A_W-1:0]  a_r;
  logic signed [MUL_HI_W-1:0] hi_r, hi_nxt;
  logic [MUL_B_W-1:0]         lo_r, lo_nxt;
  logic signed [MUL_HI_W+DIG_W-1:0] pp;
  logic signed [MUL_HI_W+DIG_W-1:0] sum;

  always_comb begin
    pp     = a_r * $signed({1'b0, lo_r[DIG_W-1:0]});
    sum    = {{DIG_W{hi_r[MUL_HI_W-1]}}, hi_r} + pp;
    hi_nxt = sum[MUL_HI_W+DIG_W-1:DIG_W];
    lo_nxt = {sum[DIG_W-1:0], lo_r[MUL_B_W-1:DIG_W]};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == MUL_CNT_W'(MUL_DIGITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

FILE: rtl/core/cpj_err_store.sv
// ----------------------------------------------------------------------------
// cpj_err_store
// Per-joint stored errors of the position, velocity and acceleration stages.
// ----------------------------------------------------------------------------
module cpj_err_store (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cpj_pkg::stage_t                    stage,
  input  logic [cpj_pkg::JOINT_W-1:0]        joint,
  input  logic                               we,
  input  logic signed [cpj_pkg::DATA_W-1:0]  wdata,
  output logic signed [cpj_pkg::DATA_W-1:0]  rdata
);
  import cpj_pkg::*;

  logic signed [DATA_W-1:0] pos_err_r [JOINTS];
  logic signed [DATA_W-1:0] vel_err_r [JOINTS];
  logic signed [DATA_W-1:0] acc_err_r [JOINTS];

  always_comb begin
    case (stage)
      STG_POS: rdata = pos_err_r[joint];
      STG_VEL: rdata = vel_err_r[joint];
      STG_ACC: rdata = acc_err_r[joint];
      default: rdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < JOINTS; k++) begin
        pos_err_r[k] <= '0;
        vel_err_r[k] <= '0;
        acc_err_r[k] <= '0;
      end
    end else if (we) begin
      case (stage)
        STG_POS: pos_err_r[joint] <= wdata;
        STG_VEL: vel_err_r[joint] <= wdata;
        STG_ACC: acc_err_r[joint] <= wdata;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/cpj_ctrl.sv
// ----------------------------------------------------------------------------
// cpj_ctrl
// Sequencer for the three cascaded PD stages; drives the shared digit-serial
// multiplier and the stored-error bank.
// ----------------------------------------------------------------------------
module cpj_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  cpj_pkg::item_t   item,
  input  cpj_pkg::gains_t  gains,
  output logic             idle,
  output logic             res_valid,
  input  logic             res_ready,
  output cpj_pkg::result_t res
);
  import cpj_pkg::*;

  state_t state_r, state_nxt;
  stage_t stage_r, stage_nxt;
  op_t    op_r, op_nxt;

  logic [JOINT_W-1:0]       joint_r, joint_nxt;
  logic                     restart_r, restart_nxt;
  logic signed [DATA_W-1:0] ref_r, ref_nxt;
  logic signed [DATA_W-1:0] pos_r, pos_nxt;
  logic signed [DATA_W-1:0] vel_r, vel_nxt;
  logic signed [DATA_W-1:0] acc_r, acc_nxt;
  logic signed [DATA_W-1:0] err_r, err_nxt;
  logic signed [DATA_W:0]   diff_r, diff_nxt;
  logic signed [PQ_W-1:0]   p_r, p_nxt;
  logic signed [DATA_W-1:0] t_r, t_nxt;
  logic signed [PQ_W-1:0]   d_r, d_nxt;
  logic signed [DATA_W-1:0] jerk_r, jerk_nxt;

  logic signed [DATA_W-1:0]  meas;
  logic signed [DATA_W:0]    raw_err;
  logic signed [DATA_W-1:0]  err;
  logic signed [DATA_W-1:0]  stored;
  logic signed [DATA_W-1:0]  prev;
  logic signed [DATA_W-1:0]  stage_out;
  logic                      store_we;
  logic signed [DATA_W-1:0]  store_rdata;

  logic                      mul_start;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic                      mul_done;
  logic signed [MUL_P_W-1:0] mul_prod;
  logic signed [PQ_W-1:0]    prod_q;
  logic [GAIN_W-1:0]         p_gain;
  logic [GAIN_W-1:0]         d_gain;

  cpj_serial_mult u_mult (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  cpj_err_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .stage (stage_r),
    .joint (joint_r),
    .we    (store_we),
    .wdata (err),
    .rdata (store_rdata)
  );

  always_comb begin
    case (stage_r)
      STG_POS: begin
        meas   = pos_r;
        p_gain = gains.pos_p;
        d_gain = gains.pos_d;
      end
      STG_VEL: begin
        meas   = vel_r;
        p_gain = gains.vel_p;
        d_gain = gains.vel_d;
      end
      default: begin
        meas   = acc_r;
        p_gain = gains.acc_p;
        d_gain = gains.acc_d;
      end
    endcase

    raw_err = {ref_r[DATA_W-1], ref_r} - {meas[DATA_W-1], meas};
    err     = sat32({{(SAT_W-DATA_W-1){raw_err[DATA_W]}}, raw_err});
    stored  = restart_r ? '0 : store_rdata;
    prev    = (stored == '0) ? err : stored;

    case (op_r)
      OP_P: begin
        mul_a = {err_r[DATA_W-1], err_r};
        mul_b = MUL_B_W'(p_gain);
      end
      OP_D: begin
        mul_a = diff_r;
        mul_b = MUL_B_W'(d_gain);
      end
      default: begin
        mul_a = {t_r[DATA_W-1], t_r};
        mul_b = MUL_B_W'(gains.inv_t);
      end
    endcase

    prod_q    = mul_prod[MUL_P_W-1:FRAC_W];
    stage_out = sat32({p_r[PQ_W-1], p_r} + {d_r[PQ_W-1], d_r});
  end

  always_comb begin
    state_nxt   = state_r;
    stage_nxt   = stage_r;
    op_nxt      = op_r;
    joint_nxt   = joint_r;
    restart_nxt = restart_r;
    ref_nxt     = ref_r;
    pos_nxt     = pos_r;
    vel_nxt     = vel_r;
    acc_nxt     = acc_r;
    err_nxt     = err_r;
    diff_nxt    = diff_r;
    p_nxt       = p_r;
    t_nxt       = t_r;
    d_nxt       = d_r;
    jerk_nxt    = jerk_r;
    idle        = 1'b0;
    res_valid   = 1'b0;
    store_we    = 1'b0;
    mul_start   = 1'b0;

    case (state_r)
      S_IDLE: begin
        idle = 1'b1;
        if (start) begin
          joint_nxt   = item.joint;
          restart_nxt = item.restart;
          ref_nxt     = item.goal;
          pos_nxt     = item.pos;
          vel_nxt     = item.vel;
          acc_nxt     = item.acc;
          stage_nxt   = STG_POS;
          if (item.joint > JOINT_MAX) begin
            jerk_nxt  = '0;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_ERR;
          end
        end
      end
      S_ERR: begin
        store_we  = 1'b1;
        err_nxt   = err;
        diff_nxt  = {err[DATA_W-1], err} - {prev[DATA_W-1], prev};
        op_nxt    = OP_P;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        mul_start = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (mul_done) begin
          case (op_r)
            OP_P: begin
              p_nxt     = prod_q;
              op_nxt    = OP_D;
              state_nxt = S_LOAD;
            end
            OP_D: begin
              t_nxt     = sat32({prod_q[PQ_W-1], prod_q});
              op_nxt    = OP_SCALE;
              state_nxt = S_LOAD;
            end
            default: begin
              d_nxt     = prod_q;
              state_nxt = S_SUM;
            end
          endcase
        end
      end
      S_SUM: begin
        ref_nxt = stage_out;
        case (stage_r)
          STG_POS: begin
            stage_nxt = STG_VEL;
            state_nxt = S_ERR;
          end
          STG_VEL: begin
            stage_nxt = STG_ACC;
            state_nxt = S_ERR;
          end
          default: begin
            jerk_nxt  = stage_out;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stage_r <= STG_POS;
      op_r    <= OP_P;
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
      op_r    <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    joint_r   <= joint_nxt;
    restart_r <= restart_nxt;
    ref_r     <= ref_nxt;
    pos_r     <= pos_nxt;
    vel_r     <= vel_nxt;
    acc_r     <= acc_nxt;
    err_r     <= err_nxt;
    diff_r    <= diff_nxt;
    p_r       <= p_nxt;
    t_r       <= t_nxt;
    d_r       <= d_nxt;
    jerk_r    <= jerk_nxt;
  end

  assign res.joint = joint_r;
  assign res.jerk  = jerk_r;

endmodule

FILE: rtl/core/cascade_pd_jerk_controller.sv
// ----------------------------------------------------------------------------
// cascade_pd_jerk_controller
// An item with a valid joint is worked through the three PD stages in turn, and
// no new item is taken until its result has left the sequencer for the output
// register. Each stage runs three multiplies on one shared 4-bit-digit serial
// multiplier, plus an error step and a sum step. A joint out of range gives a
// zero command without any multiply. Synchronous active-low reset restores
// the gain defaults and zeroes stored errors; items are taken right after.
// ----------------------------------------------------------------------------
module cascade_pd_jerk_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: joint_index[2:0], goal_position[34:3], position[66:35],
  //           velocity[98:67], acceleration[130:99], zero fill above.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [cpj_pkg::IN_TDATA_W-1:0]       in_tdata,
  // in_tuser: restart[0].
  input  logic                                 in_tuser,
  // out_tdata: joint_out[2:0], jerk_command[34:3], zero fill above.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [cpj_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                 cfg_wen,
  input  logic [cpj_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cpj_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import cpj_pkg::*;

  gains_t  gains_r, gains_nxt;
  item_t   item;
  result_t res;
  logic    ctrl_idle;
  logic    res_valid;
  logic    res_ready;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  always_comb begin
    gains_nxt = gains_r;
    if (cfg_wen) begin
      case (cfg_index)
        REG_POS_P: gains_nxt.pos_p = cfg_wdata[GAIN_W-1:0];
        REG_POS_D: gains_nxt.pos_d = cfg_wdata[GAIN_W-1:0];
        REG_VEL_P: gains_nxt.vel_p = cfg_wdata[GAIN_W-1:0];
        REG_VEL_D: gains_nxt.vel_d = cfg_wdata[GAIN_W-1:0];
        REG_ACC_P: gains_nxt.acc_p = cfg_wdata[GAIN_W-1:0];
        REG_ACC_D: gains_nxt.acc_d = cfg_wdata[GAIN_W-1:0];
        REG_INV_T: gains_nxt.inv_t = cfg_wdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.pos_p <= GAIN_W'(196608);
      gains_r.pos_d <= GAIN_W'(64881);
      gains_r.vel_p <= GAIN_W'(137626);
      gains_r.vel_d <= GAIN_W'(6554);
      gains_r.acc_p <= GAIN_W'(655360);
      gains_r.acc_d <= GAIN_W'(32768);
      gains_r.inv_t <= INV_W'(8192000);
    end else begin
      gains_r <= gains_nxt;
    end
  end

  assign item.joint   = in_tdata[2:0];
  assign item.restart = in_tuser;
  assign item.goal    = in_tdata[34:3];
  assign item.pos     = in_tdata[66:35];
  assign item.vel     = in_tdata[98:67];
  assign item.acc     = in_tdata[130:99];

  assign in_tready = ctrl_idle;

  cpj_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_tvalid & ctrl_idle),
    .item      (item),
    .gains     (gains_r),
    .idle      (ctrl_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-JOINT_W-DATA_W){1'b0}}, out_res_r.jerk, out_res_r.joint};

endmodule

FILE: rtl/core/cpj_checker.sv
// ----------------------------------------------------------------------------
// cpj_checker
// Port-level checks of the cascaded PD jerk controller, bound to the top.
// ----------------------------------------------------------------------------
module cpj_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [cpj_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import cpj_pkg::*;

  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  a_bad_joint_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2:0] > JOINT_MAX) |-> out_tdata[34:3] == '0)
    else $error("nonzero command for joint out of range");

endmodule

bind cascade_pd_jerk_controller cpj_checker u_cpj_checker (.*);

FILE: tb/tb_cascade_pd_jerk_controller.sv
// ----------------------------------------------------------------------------
// tb_cascade_pd_jerk_controller
// Self-checking bench for the cascaded PD jerk controller. A directed table
// covers reset behavior, the saturation extremes, joints out of range and
// restarts. Random phases then follow, each with its own gain setting. Every
// jerk command is compared with a fixed-point model of the three PD stages
// kept inside the bench. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_cascade_pd_jerk_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import cpj_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 100;
  localparam int MAX_REPORTS  = 10;
  localparam int INV_HIGH     = 67108864;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  localparam logic signed [DATA_W-1:0] Q_MAXV = 32'sh7FFFFFFF;
  localparam logic signed [DATA_W-1:0] Q_MINV = 32'sh80000000;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -Q_MAX - 1;

  localparam gains_t GAINS_RESET = '{
    pos_p: 24'd196608, pos_d: 24'd64881, vel_p: 24'd137626, vel_d: 24'd6554,
    acc_p: 24'd655360, acc_d: 24'd32768, inv_t: 27'd8192000
  };

  typedef struct {
    item_t                    it;
    bit                       typed;
    logic signed [DATA_W-1:0] jerk;
  } dir_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wen    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  gains_t                   gains;
  logic signed [DATA_W-1:0] held_pos_err [JOINTS];
  logic signed [DATA_W-1:0] held_vel_err [JOINTS];
  logic signed [DATA_W-1:0] held_acc_err [JOINTS];
  result_t                  pending_cmds [$];
  dir_row_t                 dir_rows [$];

  bit calm;
  int rx_hold;
  int bad_cnt;
  int items_sent;
  int results_seen;
  int writes_done;
  int cycle_cnt;

  cascade_pd_jerk_controller DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  task automatic pd_stage(input longint r_in, input longint meas, input longint pg,
                          input longint dg, inout logic signed [DATA_W-1:0] held,
                          output longint stage_out);
    longint err;
    longint pterm;
    longint dterm;
    longint dscaled;
    err = clamp32(r_in - meas);
    if (held == 0) held = err[DATA_W-1:0];
    pterm = (pg * err) >>> FRAC_W;
    dterm = clamp32((dg * (err - longint'(held))) >>> FRAC_W);
    dscaled = (dterm * longint'(gains.inv_t)) >>> FRAC_W;
    held = err[DATA_W-1:0];
    stage_out = clamp32(pterm + dscaled);
  endtask

  task automatic predict_jerk(input item_t it, output result_t res);
    longint vref;
    longint aref;
    longint jcmd;
    res.joint = it.joint;
    res.jerk = '0;
    if (it.joint <= JOINT_MAX) begin
      if (it.restart) begin
        held_pos_err[it.joint] = '0;
        held_vel_err[it.joint] = '0;
        held_acc_err[it.joint] = '0;
      end
      pd_stage(longint'($signed(it.goal)), longint'($signed(it.pos)), longint'(gains.pos_p),
               longint'(gains.pos_d), held_pos_err[it.joint], vref);
      pd_stage(vref, longint'($signed(it.vel)), longint'(gains.vel_p),
               longint'(gains.vel_d), held_vel_err[it.joint], aref);
      pd_stage(aref, longint'($signed(it.acc)), longint'(gains.acc_p),
               longint'(gains.acc_d), held_acc_err[it.joint], jcmd);
      res.jerk = jcmd[DATA_W-1:0];
    end
  endtask

  function automatic logic [IN_TDATA_W-1:0] pack_item(input item_t it);
    logic [IN_TDATA_W-1:0] v;
    v = '0;
    v[2:0]    = it.joint;
    v[34:3]   = it.goal;
    v[66:35]  = it.pos;
    v[98:67]  = it.vel;
    v[130:99] = it.acc;
    return v;
  endfunction

  function automatic logic signed [DATA_W-1:0] random_q16();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 3))
          0: return Q_MAXV;
          1: return Q_MINV;
          2: return '0;
          default: return -32'sd1;
        endcase
      end
      default: return $urandom_range(0, 32'h7FFFF) - 32'd262144;
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.joint = ($urandom_range(0, 19) == 0) ? JOINT_W'($urandom_range(JOINTS, 7))
                                            : JOINT_W'($urandom_range(0, JOINTS - 1));
    it.restart = ($urandom_range(0, 15) == 0);
    it.goal = random_q16();
    it.pos = ($urandom_range(0, 9) == 0) ? it.goal : random_q16();
    it.vel = random_q16();
    it.acc = random_q16();
    return it;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] phase_value(input int ph, input int r);
    case (ph)
      0: return (r == REG_INV_T) ? CFG_DATA_W'($urandom_range(1, INV_HIGH))
                                 : CFG_DATA_W'($urandom_range(0, 20'hFFFFF));
      1: return CFG_DATA_W'($urandom);
      2: return '1;
      3: return '0;
      4: return (r == REG_INV_T) ? 27'd1 : CFG_DATA_W'($urandom_range(0, 18'h3FFFF));
      default: begin
        case (r)
          REG_POS_P: return CFG_DATA_W'(GAINS_RESET.pos_p);
          REG_POS_D: return CFG_DATA_W'(GAINS_RESET.pos_d);
          REG_VEL_P: return CFG_DATA_W'(GAINS_RESET.vel_p);
          REG_VEL_D: return CFG_DATA_W'(GAINS_RESET.vel_d);
          REG_ACC_P: return CFG_DATA_W'(GAINS_RESET.acc_p);
          REG_ACC_D: return CFG_DATA_W'(GAINS_RESET.acc_d);
          default: return CFG_DATA_W'(INV_HIGH);
        endcase
      end
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_POS_P: gains.pos_p = val[GAIN_W-1:0];
      REG_POS_D: gains.pos_d = val[GAIN_W-1:0];
      REG_VEL_P: gains.vel_p = val[GAIN_W-1:0];
      REG_VEL_D: gains.vel_d = val[GAIN_W-1:0];
      REG_ACC_P: gains.acc_p = val[GAIN_W-1:0];
      REG_ACC_D: gains.acc_d = val[GAIN_W-1:0];
      REG_INV_T: gains.inv_t = val;
      default: ;
    endcase
    writes_done++;
  endtask

  task automatic send_item(input item_t it, input bit typed,
                           input logic signed [DATA_W-1:0] typed_jerk);
    int gap;
    result_t want;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pack_item(it);
    in_tuser <= it.restart;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_jerk(it, want);
    if (typed) want.jerk = typed_jerk;
    pending_cmds.push_back(want);
    items_sent++;
  endtask

  task automatic finish_phase();
    in_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic add_row(input int joint, input bit restart, input logic signed [31:0] goal,
                         input logic signed [31:0] pos, input logic signed [31:0] vel,
                         input logic signed [31:0] acc, input bit typed,
                         input logic signed [31:0] jerk);
    dir_row_t row;
    row.it.joint = joint[JOINT_W-1:0];
    row.it.restart = restart;
    row.it.goal = goal;
    row.it.pos = pos;
    row.it.vel = vel;
    row.it.acc = acc;
    row.typed = typed;
    row.jerk = jerk;
    dir_rows.push_back(row);
  endtask

  task automatic check_result(input logic [OUT_TDATA_W-1:0] word);
    result_t want;
    logic [JOINT_W-1:0] got_joint;
    logic signed [DATA_W-1:0] got_jerk;
    got_joint = word[2:0];
    got_jerk = word[34:3];
    if (pending_cmds.size() == 0) begin
      bad_cnt++;
      if (bad_cnt <= MAX_REPORTS)
        $display("Unexpected item on output: joint %0d jerk %h", got_joint, got_jerk);
    end else begin
      want = pending_cmds.pop_front();
      results_seen++;
      if (want.joint !== got_joint || want.jerk !== got_jerk) begin
        bad_cnt++;
        if (bad_cnt <= MAX_REPORTS)
          $display("Mismatch on result %0d: expected joint %0d jerk %h, got joint %0d jerk %h",
                   results_seen, want.joint, want.jerk, got_joint, got_jerk);
      end
    end
  endtask

  always @(posedge clk) begin : rx_side
    int n;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold <= 0;
    end else if (out_tvalid && out_tready) begin
      check_result(out_tdata);
      n = draw_gap();
      out_tready <= (n == 0);
      rx_hold <= n;
    end else if (out_tvalid) begin
      if (rx_hold <= 1) out_tready <= 1'b1;
      rx_hold <= (rx_hold > 0) ? rx_hold - 1 : 0;
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timed out after %0d cycles with %0d results outstanding",
             cycle_cnt, pending_cmds.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int n_directed;
    gains = GAINS_RESET;
    for (int k = 0; k < JOINTS; k++) begin
      held_pos_err[k] = '0;
      held_vel_err[k] = '0;
      held_acc_err[k] = '0;
    end
    calm = 1'b0;

    add_row(0, 0, 0, 0, 0, 0, 1, 0);
    add_row(0, 1, Q_MAXV, Q_MINV, 0, 0, 1, Q_MAXV);
    add_row(0, 0, Q_MINV, Q_MAXV, 0, 0, 0, 0);
    add_row(0, 1, Q_MINV, Q_MAXV, 0, 0, 1, Q_MINV);
    add_row(6, 1, 32'sh00010000, 0, 32'sh00001000, 0, 1, 0);
    add_row(7, 0, Q_MAXV, Q_MAXV, Q_MAXV, Q_MAXV, 1, 0);
    add_row(1, 0, 32'sh00010000, 0, 0, 0, 0, 0);
    add_row(1, 0, 32'sh00010000, 32'sh00010000, 0, 0, 0, 0);
    add_row(1, 0, 32'sh00020000, 0, 0, 0, 0, 0);
    add_row(2, 0, 0, 0, Q_MAXV, Q_MINV, 0, 0);
    add_row(2, 0, 0, 0, Q_MINV, Q_MAXV, 0, 0);
    add_row(3, 0, -32'sd1, 0, -32'sd1, 32'sd1, 0, 0);
    add_row(3, 0, 32'sd1, -32'sd1, 32'sd1, -32'sd1, 0, 0);
    add_row(4, 1, 32'sh12345678, 32'sh0F000000, 32'sh00100000, -32'sh00100000, 0, 0);
    add_row(4, 0, 32'sh12345678, 32'sh12340000, 32'sh00080000, 32'sh00040000, 0, 0);
    add_row(5, 0, Q_MAXV, Q_MAXV, Q_MAXV, Q_MAXV, 0, 0);
    add_row(5, 0, Q_MINV, Q_MINV, Q_MINV, Q_MINV, 0, 0);
    add_row(5, 1, 0, 0, 0, 0, 1, 0);
    add_row(7, 1, Q_MINV, Q_MAXV, -32'sd1, 32'sd1, 1, 0);
    add_row(0, 0, 0, 0, 0, 0, 0, 0);
    add_row(1, 1, 32'sh40000000, -32'sh40000000, 0, 0, 0, 0);
    add_row(2, 0, 32'sh00003000, 32'sh00001000, -32'sh00000800, 32'sh00000100, 0, 0);
    n_directed = dir_rows.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].jerk);
    finish_phase();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      for (int r = 0; r <= REG_INV_T; r++) write_reg(r[CFG_IDX_W-1:0], phase_value(ph, r));
      if (ph == 1 || ph == 2) write_reg(REG_NONE, CFG_DATA_W'($urandom));
      cfg_wen <= 1'b0;
      calm = (ph == 2 || ph == 5);
      for (int k = 0; k < PHASE_ITEMS; k++) send_item(random_item(), 1'b0, '0);
      finish_phase();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_cmds.size() != 0) begin
      bad_cnt += pending_cmds.size();
      $display("%0d jerk commands never arrived", pending_cmds.size());
    end

    $display("Sent %0d items (%0d from the directed table) and checked %0d jerk commands.",
             items_sent, n_directed, results_seen);
    $display("Covered %0d gain settings through %0d register writes, %0d failures.",
             RAND_PHASES + 1, writes_done, bad_cnt);
    if (bad_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
